FILE: sv/rotating_codebook_rank_select_codec_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rotating codebook rank/select codec
// Shared clocking and reset for the concurrent checks of the codec.
// ---------------------------------------------------------------------------
`ifndef ROTATING_CODEBOOK_RANK_SELECT_CODEC_CORE_MACROS_SVH
`define ROTATING_CODEBOOK_RANK_SELECT_CODEC_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RCRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rcrs: implication check failed");

// Next-cycle implication, checked out of reset.
`define RCRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rcrs: next-cycle check failed");

`endif

FILE: sv/rcrs_pkg.sv
// ---------------------------------------------------------------------------
// rcrs_pkg
// Constants, opcodes and controller/datapath link types of the codec.
// ---------------------------------------------------------------------------
`default_nettype none

package rcrs_pkg;

  localparam int BETA          = 4;
  localparam int NU            = 16;
  localparam int VALUE_LIMIT   = ((1 << (2 * BETA)) < 256) ? (1 << (2 * BETA)) : 256;
  localparam int MAX_COUNT     = (NU < 16) ? NU : 16;

  // Bitmap memory: one 16-bit row per access, 16 rows per codebook
  localparam int ROW_BITS      = 16;
  localparam int BIT_SEL_W     = $clog2(ROW_BITS);
  localparam int ROWS_PER_BANK = 16;
  localparam int ROW_SEL_W     = $clog2(ROWS_PER_BANK);
  localparam int BANKS         = 16;
  localparam int BANK_W        = $clog2(BANKS);
  localparam int MEM_ROWS      = BANKS * ROWS_PER_BANK;
  localparam int ADDR_W        = $clog2(MEM_ROWS);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_DECODE = 2'd2
  } rcrs_op_e;

  localparam logic CFG_SYMBOL_BITS    = 1'b0;
  localparam logic CFG_CODEBOOK_COUNT = 1'b1;

  typedef struct packed {
    logic                 accept;
    logic                 issue;
    logic [ROW_SEL_W-1:0] row;
    logic                 load_out;
  } rcrs_cmd_t;

  typedef struct packed {
    logic scan_req;
    logic scan_done;
    logic out_free;
  } rcrs_status_t;

endpackage

`default_nettype wire

FILE: sv/rotating_codebook_rank_select_codec_core.sv
// ---------------------------------------------------------------------------
// rotating_codebook_rank_select_codec_core
// Rank/select codec over per-codebook membership bitmaps with rotation.
// ---------------------------------------------------------------------------
// Requests enter on the in_valid_i/in_ready_o channel, results leave on the
// out_valid_o/out_ready_i channel; configuration is a plain write port
// (index 0 symbol_bits, index 1 codebook_count), written while idle.
// A load request gives no result and leaves the block idle; opcode 3 likewise.
// An encode or decode request walks the current codebook's bitmap one
// 16-bit row per cycle through a single memory read port and one popcount
// unit: a decode stops at its target row, an encode at its hit row or at
// the last row, and the result then goes to the output register. One
// request is in work at a time; in_ready_o returns high as the result
// enters the output register, so the next request can be accepted while
// the result waits.
// A stalled receiver holds the result; a finished scan then waits for the
// output register before the block goes idle again.
// Reset clears the rotation position, restores symbol_bits 4 and
// codebook_count 1, and marks every bitmap row unwritten, so all
// codebooks read empty at once with no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module rotating_codebook_rank_select_codec_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic       restart_i,
  input  logic [7:0] word_index_i,
  input  logic [3:0] bank_i,
  input  logic       bit_value_i,
  input  logic [6:0] symbol_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] codeword_o,
  output logic [6:0] decoded_symbol_o,
  output logic       error_o
);
  import rcrs_pkg::*;

  rcrs_cmd_t    cmd;
  rcrs_status_t status;

  rcrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  rcrs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .restart_i        (restart_i),
    .word_index_i     (word_index_i),
    .bank_i           (bank_i),
    .bit_value_i      (bit_value_i),
    .symbol_i         (symbol_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .codeword_o       (codeword_o),
    .decoded_symbol_o (decoded_symbol_o),
    .error_o          (error_o)
  );

endmodule

`default_nettype wire

FILE: sv/rcrs_ctrl.sv
// ---------------------------------------------------------------------------
// rcrs_ctrl
// Sequencer: accepts requests, walks the codebook rows, hands off results.
// ---------------------------------------------------------------------------
`default_nettype none

module rcrs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output rcrs_pkg::rcrs_cmd_t    cmd_o,
  input  rcrs_pkg::rcrs_status_t status_i
);
  import rcrs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e               state_q;
  logic [ROW_SEL_W-1:0] iss_q;
  logic                 iss_end_q;

  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    cmd_o.accept    = in_ready_o && in_valid_i;
    cmd_o.issue     = (state_q == S_SCAN) && !iss_end_q && !status_i.scan_done;
    cmd_o.row       = iss_q;
    cmd_o.load_out  = (state_q == S_FINISH) && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= '0;
      iss_end_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.accept && status_i.scan_req) begin
            state_q   <= S_SCAN;
            iss_q     <= '0;
            iss_end_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (status_i.scan_done) begin
            state_q <= S_FINISH;
          end else if (cmd_o.issue) begin
            iss_q <= iss_q + ROW_SEL_W'(1);
            if (iss_q == ROW_SEL_W'(ROWS_PER_BANK - 1)) begin
              iss_end_q <= 1'b1;
            end
          end
        end
        S_FINISH: begin
          // hold until the output register can take the result
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/rcrs_datapath.sv
// ---------------------------------------------------------------------------
// rcrs_datapath
// Bitmap memory, rotation position, shared popcount scan and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rotating_codebook_rank_select_codec_core_macros.svh"

module rcrs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [4:0]             cfg_data_i,
  input  logic [1:0]             opcode_i,
  input  logic                   restart_i,
  input  logic [7:0]             word_index_i,
  input  logic [3:0]             bank_i,
  input  logic                   bit_value_i,
  input  logic [6:0]             symbol_i,
  input  rcrs_pkg::rcrs_cmd_t    cmd_i,
  output rcrs_pkg::rcrs_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             codeword_o,
  output logic [6:0]             decoded_symbol_o,
  output logic                   error_o
);
  import rcrs_pkg::*;

  function automatic logic [BIT_SEL_W:0] popcount16(input logic [ROW_BITS-1:0] w);
    logic [BIT_SEL_W:0] n;
    n = '0;
    for (int k = 0; k < ROW_BITS; k++) begin
      n = n + (BIT_SEL_W + 1)'(w[k]);
    end
    return n;
  endfunction

  // position of the set bit that has r set bits below it
  function automatic logic [BIT_SEL_W-1:0] select16(input logic [ROW_BITS-1:0] w,
                                                    input logic [BIT_SEL_W-1:0] r);
    logic [BIT_SEL_W-1:0] pos;
    logic [ROW_BITS-1:0]  below;
    pos = '0;
    for (int k = 0; k < ROW_BITS; k++) begin
      below = (ROW_BITS'(1) << k) - ROW_BITS'(1);
      if (w[k] && (popcount16(w & below) == {1'b0, r})) begin
        pos = BIT_SEL_W'(k);
      end
    end
    return pos;
  endfunction

  // configuration
  logic [2:0] symbol_bits_q;
  logic [4:0] codebook_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_bits_q    <= 3'd4;
      codebook_count_q <= 5'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SYMBOL_BITS) begin
        symbol_bits_q <= cfg_data_i[2:0];
      end else begin
        codebook_count_q <= cfg_data_i;
      end
    end
  end

  logic [4:0] cnt;
  logic [2:0] sym_bits;
  logic [7:0] nsym;

  always_comb begin
    if (codebook_count_q == 5'd0) begin
      cnt = 5'd1;
    end else if (int'(codebook_count_q) > MAX_COUNT) begin
      cnt = 5'(MAX_COUNT);
    end else begin
      cnt = codebook_count_q;
    end
    sym_bits = (symbol_bits_q == 3'd0) ? 3'd1 : symbol_bits_q;
    nsym     = 8'd1 << sym_bits;
  end

  // rotation position
  logic [BANK_W-1:0] seg_q;
  logic [BANK_W-1:0] cur_pick;
  logic [BANK_W-1:0] seg_d;
  logic              scan_req;

  always_comb begin
    cur_pick = restart_i ? '0 : seg_q;
    if ({1'b0, cur_pick} >= cnt) begin
      cur_pick = '0;
    end
    seg_d    = (({1'b0, cur_pick} + 5'd1) == cnt) ? '0 : (cur_pick + BANK_W'(1));
    scan_req = (opcode_i == OP_ENCODE) || (opcode_i == OP_DECODE);
  end

  // item registers
  rcrs_op_e          op_q;
  logic [6:0]        sym_q;
  logic [7:0]        widx_q;
  logic [BANK_W-1:0] cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= '0;
      op_q   <= OP_LOAD;
      sym_q  <= '0;
      widx_q <= '0;
      cur_q  <= '0;
    end else if (cmd_i.accept && scan_req) begin
      seg_q  <= seg_d;
      op_q   <= rcrs_op_e'(opcode_i);
      sym_q  <= symbol_i;
      widx_q <= word_index_i;
      cur_q  <= cur_pick;
    end
  end

  // bitmap memory; a row never written reads as zero
  logic [ROW_BITS-1:0] mem_q [MEM_ROWS];
  logic [MEM_ROWS-1:0] row_vld_q;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  logic [ROW_BITS-1:0] wmask;
  logic [ROW_BITS-1:0] wdata;
  logic                load_hit;
  logic [ROW_BITS-1:0] rdata_q;
  logic                rd_live_q;
  logic                rd_vld_q;
  logic [ROW_SEL_W-1:0] rd_row_q;

  always_comb begin
    waddr    = {bank_i, word_index_i[7:BIT_SEL_W]};
    raddr    = {cur_q, cmd_i.row};
    wmask    = row_vld_q[waddr] ? (ROW_BITS'(1) << word_index_i[BIT_SEL_W-1:0]) : '1;
    wdata    = ROW_BITS'(bit_value_i) << word_index_i[BIT_SEL_W-1:0];
    load_hit = cmd_i.accept && (opcode_i == OP_LOAD) && (int'(bank_i) < NU)
               && (int'(word_index_i) < VALUE_LIMIT);
  end

  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      for (int k = 0; k < ROW_BITS; k++) begin
        if (wmask[k]) begin
          mem_q[waddr][k] <= wdata[k];
        end
      end
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_row_q  <= '0;
      rd_live_q <= 1'b0;
    end else begin
      if (load_hit) begin
        row_vld_q[waddr] <= 1'b1;
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.issue) begin
        rd_row_q  <= cmd_i.row;
        rd_live_q <= row_vld_q[raddr];
      end
    end
  end

  // scan: one row per cycle through the shared popcount
  logic [ROW_BITS-1:0]  word;
  logic [ROW_BITS-1:0]  mask;
  logic                 is_tgt;
  logic [BIT_SEL_W:0]   pop;
  logic [8:0]           seen_sum;
  logic [8:0]           seen_q;
  logic                 found_q;
  logic                 done_q;
  logic                 member_q;
  logic [ROW_BITS-1:0]  hit_word_q;
  logic [ROW_SEL_W-1:0] hit_row_q;
  logic [BIT_SEL_W-1:0] rem_q;
  logic                 step;

  always_comb begin
    word     = rd_live_q ? rdata_q : '0;
    is_tgt   = (rd_row_q == widx_q[7:BIT_SEL_W]);
    mask     = ((op_q == OP_DECODE) && is_tgt)
               ? ((ROW_BITS'(1) << widx_q[BIT_SEL_W-1:0]) - ROW_BITS'(1)) : '1;
    pop      = popcount16(word & mask);
    seen_sum = seen_q + 9'(pop);
    step     = rd_vld_q && !done_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      member_q   <= 1'b0;
      hit_word_q <= '0;
      hit_row_q  <= '0;
      rem_q      <= '0;
    end else if (cmd_i.accept && scan_req) begin
      seen_q   <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      member_q <= 1'b0;
    end else if (step) begin
      unique case (op_q)
        OP_ENCODE: begin
          if (seen_sum > 9'(sym_q)) begin
            found_q    <= 1'b1;
            done_q     <= 1'b1;
            hit_word_q <= word;
            hit_row_q  <= rd_row_q;
            rem_q      <= BIT_SEL_W'(sym_q - seen_q[6:0]);
          end else begin
            seen_q <= seen_sum;
            if (rd_row_q == ROW_SEL_W'(ROWS_PER_BANK - 1)) begin
              done_q <= 1'b1;
            end
          end
        end
        OP_DECODE: begin
          seen_q <= seen_sum;
          if (is_tgt) begin
            member_q <= word[widx_q[BIT_SEL_W-1:0]];
            done_q   <= 1'b1;
          end
        end
        default: done_q <= 1'b1;
      endcase
    end
  end

  // result register
  logic                 enc_err;
  logic                 dec_err;
  logic [BIT_SEL_W-1:0] pos;
  logic                 out_valid_q;
  logic [7:0]           codeword_q;
  logic [6:0]           decoded_q;
  logic                 error_q;

  always_comb begin
    enc_err = ({1'b0, sym_q} >= nsym) || !found_q;
    dec_err = (int'(widx_q) >= VALUE_LIMIT) || !member_q || (seen_q >= {1'b0, nsym});
    pos     = select16(hit_word_q, rem_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      codeword_q  <= '0;
      decoded_q   <= '0;
      error_q     <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
      if (op_q == OP_ENCODE) begin
        codeword_q <= enc_err ? '0 : {hit_row_q, pos};
        decoded_q  <= '0;
        error_q    <= enc_err;
      end else begin
        codeword_q <= '0;
        decoded_q  <= dec_err ? '0 : seen_q[6:0];
        error_q    <= dec_err;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    status_o.scan_req  = scan_req;
    status_o.scan_done = done_q;
    status_o.out_free  = !out_valid_q || out_ready_i;
    out_valid_o        = out_valid_q;
    codeword_o         = codeword_q;
    decoded_symbol_o   = decoded_q;
    error_o            = error_q;
  end

  `RCRS_ASSERT_IMPL(a_no_overwrite, cmd_i.load_out, !out_valid_q || out_ready_i)
  `RCRS_ASSERT_IMPL(a_hit_ends_scan, found_q, done_q)
  `RCRS_ASSERT_IMPL(a_enc_seen_bound, (op_q == OP_ENCODE) && !found_q, seen_q <= 9'(sym_q))
  `RCRS_ASSERT_NEXT(a_scan_cleared, cmd_i.accept && scan_req, !done_q && (seen_q == '0))

endmodule

`default_nettype wire
